// ===== hdl/hsv2rgb_pkg.sv =====
`default_nettype none

package hsv2rgb_pkg;

  localparam int DEF_INDEX_BITS = 10;

  localparam int HUE_W  = 16;
  localparam int SAT_W  = 13;
  localparam int VAL_W  = 13;
  localparam int FRAC_W = 12;
  localparam int K_W    = 24;
  localparam int PROD_W = VAL_W + K_W;
  localparam int DIV_W  = 12;

  localparam logic [HUE_W-1:0]  HUE_TURN   = 16'd23040;
  localparam logic [HUE_W-1:0]  HUE_TURN2  = 16'd46080;
  localparam logic [HUE_W-1:0]  HUE_SECTOR = 16'd3840;
  localparam logic [SAT_W-1:0]  ONE_Q12    = 13'd4096;
  localparam logic [K_W-1:0]    KFULL      = 24'd15728640;
  // Half of the full-scale denominator 2^32 * 15, used for round to nearest.
  localparam logic [PROD_W+7:0] ROUND_HALF = 45'd32212254720;
  // 65535 / 15; (y + 1) * RECIP_15 >> 16 is exact floor(y / 15) for y < 4096.
  localparam logic [12:0]       RECIP_15   = 13'd4369;

  typedef logic [K_W-1:0]   kterm_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

// ===== hdl/hsv2rgb_lane.sv =====
`default_nettype none

module hsv2rgb_lane
  import hsv2rgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [2:0] en,
  input  wire val_t       v,
  input  wire kterm_t     k,
  output logic [7:0]      chan
);

  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  quot;
  logic [PROD_W+7:0] scaled;
  logic [25:0]       recip;

  // 255 * prod as a shift and subtract, plus the rounding offset.
  assign scaled = ({prod, 8'd0} - {8'd0, prod}) + ROUND_HALF;
  assign recip  = (26'(quot) + 26'd1) * 26'(RECIP_15);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= PROD_W'(v) * PROD_W'(k);
    end
    if (en[1]) begin
      quot <= scaled[43:32];
    end
    if (en[2]) begin
      chan <= recip[23:16];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_converter_core.sv =====
`default_nettype none

// HSV to RGB pixel converter.
// Input beats arrive on the s_ channel: pixel index, hue in 1/64 degree
// (wrapped modulo 360 degrees), saturation and value in Q0.12 (values above
// 1.0 are treated as 1.0). Each input beat yields exactly one output beat on
// the m_ channel with the index copied through and red, green and blue bytes.
// The datapath is an eight-stage pipeline: hue wrap, sector split, the S*F
// products, the p/q/t terms, then per channel a 13x24 multiply, a scale and
// round, and a divide by 15 through a reciprocal multiply, and finally the
// sector's channel order into the output register. m_tvalid rises when an
// accepted input beat reaches the output register, and one beat is
// accepted every cycle while the output is taken.
// Each stage has its own valid bit and holds only when it is full and the
// stage after it holds, so bubbles close up and a stalled receiver backs
// up the pipeline one stage at a time; s_tready drops only when every stage
// is full. Reset clears the valid bits; no beat is lost or repeated.
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // pixel_index, hue, saturation, brightness
  input  wire logic [((INDEX_BITS+49)/8)*8-1:0]     s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // out_index, red, green, blue
  output logic [((INDEX_BITS+31)/8)*8-1:0]          m_tdata
);

  localparam int NSTAGE = 8;
  localparam int OUT_W  = ((INDEX_BITS + 31) / 8) * 8;
  localparam int HUE_LO = INDEX_BITS;
  localparam int SAT_LO = HUE_LO + HUE_W;
  localparam int VAL_LO = SAT_LO + SAT_W;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   adv;

  logic [INDEX_BITS-1:0] idx [1:7];
  sector_t               sec [2:7];
  val_t                  v1, v2, v3, v4;
  logic [SAT_W-1:0]      s1, s2;
  logic [14:0]           hw1;
  logic [FRAC_W-1:0]     f2;
  kterm_t                sf3, sfc3, kp3;
  kterm_t                kq4, kt4, kp4;
  logic [7:0]            cv, cp, cq, ct;
  logic [7:0]            red, green, blue;
  logic [INDEX_BITS-1:0] out_index;

  logic [INDEX_BITS-1:0] in_index;
  logic [HUE_W-1:0]      in_hue;
  logic [SAT_W-1:0]      in_sat;
  logic [VAL_W-1:0]      in_val;
  logic [HUE_W-1:0]      hue_wrap;
  sector_t               sec_next;
  logic [HUE_W-1:0]      frac_next;
  logic [SAT_W-1:0]      s_inv;
  logic [K_W:0]          kp_next;
  logic [FRAC_W-1:0]     f_comp;

  assign in_index = s_tdata[INDEX_BITS-1:0];
  assign in_hue   = s_tdata[SAT_LO-1:HUE_LO];
  assign in_sat   = s_tdata[VAL_LO-1:SAT_LO];
  assign in_val   = s_tdata[VAL_LO+VAL_W-1:VAL_LO];

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    adv[NSTAGE] = m_tready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      adv[i] = ~vld[i] | adv[i+1];
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    if (in_hue >= HUE_TURN2) begin
      hue_wrap = in_hue - HUE_TURN2;
    end else if (in_hue >= HUE_TURN) begin
      hue_wrap = in_hue - HUE_TURN;
    end else begin
      hue_wrap = in_hue;
    end
  end

  always_comb begin
    if ({1'b0, hw1} >= 16'd19200) begin
      sec_next  = SEC_MAG_RED;
      frac_next = {1'b0, hw1} - 16'd19200;
    end else if ({1'b0, hw1} >= 16'd15360) begin
      sec_next  = SEC_BLU_MAG;
      frac_next = {1'b0, hw1} - 16'd15360;
    end else if ({1'b0, hw1} >= 16'd11520) begin
      sec_next  = SEC_CYN_BLU;
      frac_next = {1'b0, hw1} - 16'd11520;
    end else if ({1'b0, hw1} >= 16'd7680) begin
      sec_next  = SEC_GRN_CYN;
      frac_next = {1'b0, hw1} - 16'd7680;
    end else if ({1'b0, hw1} >= HUE_SECTOR) begin
      sec_next  = SEC_YEL_GRN;
      frac_next = {1'b0, hw1} - HUE_SECTOR;
    end else begin
      sec_next  = SEC_RED_YEL;
      frac_next = {1'b0, hw1};
    end
  end

  assign s_inv   = ONE_Q12 - s2;
  assign f_comp  = HUE_SECTOR[FRAC_W-1:0] - f2;
  // (1 - S) * 3840 as 4096x - 256x.
  assign kp_next = {s_inv, 12'd0} - {4'd0, s_inv, 8'd0};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      idx[1] <= in_index;
      s1     <= (in_sat > ONE_Q12) ? ONE_Q12 : in_sat;
      v1     <= (in_val > ONE_Q12) ? ONE_Q12 : in_val;
      hw1    <= hue_wrap[14:0];
    end
    if (adv[1]) begin
      idx[2] <= idx[1];
      sec[2] <= sec_next;
      f2     <= frac_next[FRAC_W-1:0];
      s2     <= s1;
      v2     <= v1;
    end
    if (adv[2]) begin
      idx[3] <= idx[2];
      sec[3] <= sec[2];
      v3     <= v2;
      sf3    <= K_W'(s2) * K_W'(f2);
      sfc3   <= K_W'(s2) * K_W'(f_comp);
      kp3    <= kp_next[K_W-1:0];
    end
    if (adv[3]) begin
      idx[4] <= idx[3];
      sec[4] <= sec[3];
      v4     <= v3;
      kq4    <= KFULL - sf3;
      kt4    <= KFULL - sfc3;
      kp4    <= kp3;
    end
    for (int i = 5; i <= 7; i++) begin
      if (adv[i-1]) begin
        idx[i] <= idx[i-1];
        sec[i] <= sec[i-1];
      end
    end
    if (adv[7]) begin
      out_index <= idx[7];
      unique case (sec[7])
        SEC_RED_YEL: begin red <= cv; green <= ct; blue <= cp; end
        SEC_YEL_GRN: begin red <= cq; green <= cv; blue <= cp; end
        SEC_GRN_CYN: begin red <= cp; green <= cv; blue <= ct; end
        SEC_CYN_BLU: begin red <= cp; green <= cq; blue <= cv; end
        SEC_BLU_MAG: begin red <= ct; green <= cp; blue <= cv; end
        default:     begin red <= cv; green <= cp; blue <= cq; end
      endcase
    end
  end

  hsv2rgb_lane u_lane_v (
    .clk  (clk),
    .en   (adv[6:4]),
    .v    (v4),
    .k    (KFULL),
    .chan (cv)
  );

  hsv2rgb_lane u_lane_p (
    .clk  (clk),
    .en   (adv[6:4]),
    .v    (v4),
    .k    (kp4),
    .chan (cp)
  );

  hsv2rgb_lane u_lane_q (
    .clk  (clk),
    .en   (adv[6:4]),
    .v    (v4),
    .k    (kq4),
    .chan (cq)
  );

  hsv2rgb_lane u_lane_t (
    .clk  (clk),
    .en   (adv[6:4]),
    .v    (v4),
    .k    (kt4),
    .chan (ct)
  );

  assign m_tdata = OUT_W'({blue, green, red, out_index});

endmodule

`default_nettype wire
